### hw/rtl/spo2_pkg.sv
package spo2_pkg;

  // Fixed datapath widths
  localparam int unsigned SUM_BITS   = 48;
  localparam int unsigned MUL_BITS   = 32;
  localparam int unsigned Y_BITS     = 31;
  localparam int unsigned EXP_BITS   = 6;
  localparam int unsigned FRAC_BITS  = 8;
  localparam int unsigned LOG_BITS   = EXP_BITS + FRAC_BITS;
  localparam int unsigned NUM_BITS   = 21;
  localparam int unsigned BEAT_BITS  = 4;
  localparam int unsigned PCT_BITS   = 7;

  // Defaults for the top-level parameters
  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned COUNT_BITS_DEF  = 16;

  // Ratio thresholds and scaling
  localparam int unsigned RATIO_SCALE = 100;
  localparam int unsigned RATIO_HI    = 66;
  localparam int unsigned RATIO_LO    = 50;

  // Beats between computations after reset
  localparam logic [BEAT_BITS-1:0] BEATS_RESET = BEAT_BITS'(3);

  // Saturation lookup
  localparam int unsigned TABLE_DEPTH = 43;
  localparam int unsigned IDX_BITS    = $clog2(TABLE_DEPTH);
  localparam int unsigned IDX_MAX     = TABLE_DEPTH - 1;
  localparam int unsigned SAT_FLOOR   = 93;
  localparam int unsigned SAT_CEIL    = 100;

  localparam logic [PCT_BITS-1:0] SAT_TABLE [TABLE_DEPTH] = '{
    7'd100, 7'd100, 7'd100, 7'd100, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd98,  7'd98,  7'd98,  7'd98,  7'd98, 7'd97, 7'd97, 7'd97, 7'd97, 7'd97,
    7'd97,  7'd96,  7'd96,  7'd96,  7'd96, 7'd96, 7'd96, 7'd95, 7'd95, 7'd95,
    7'd95,  7'd95,  7'd95,  7'd94,  7'd94, 7'd94, 7'd94, 7'd94, 7'd93, 7'd93,
    7'd93,  7'd93,  7'd93
  };

  // Accumulate with saturation at all ones
  function automatic logic [SUM_BITS-1:0] sat_add(input logic [SUM_BITS-1:0] a,
                                                  input logic [SUM_BITS-1:0] b);
    logic [SUM_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_BITS] ? {SUM_BITS{1'b1}} : s[SUM_BITS-1:0];
  endfunction

endpackage

### hw/rtl/spo2_smul.sv
// Radix-2 shift-add multiplier, one multiplier bit per cycle.
module spo2_smul #(
  parameter int unsigned OP_BITS = spo2_pkg::MUL_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [OP_BITS-1:0]     a_i,
  input  logic [OP_BITS-1:0]     b_i,
  output logic                   done_o,
  output logic [2*OP_BITS-1:0]   product_o
);

  localparam int unsigned CNT_BITS = $clog2(OP_BITS + 1);

  logic [CNT_BITS-1:0]  cnt_q;
  logic                 done_q;
  logic [OP_BITS-1:0]   a_q;
  logic [2*OP_BITS-1:0] prod_q, prod_d;
  logic [OP_BITS:0]     part;

  // Add multiplicand to the upper half when the low bit is set, then shift right
  always_comb begin
    part   = {1'b0, prod_q[2*OP_BITS-1:OP_BITS]} + (prod_q[0] ? {1'b0, a_q} : '0);
    prod_d = {part, prod_q[OP_BITS-1:1]};
  end

  // Step counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CNT_BITS'(OP_BITS);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - CNT_BITS'(1);
      done_q <= (cnt_q == CNT_BITS'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  // Operand and partial product
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q    <= a_i;
      prod_q <= {{OP_BITS{1'b0}}, b_i};
    end else if (cnt_q != '0) begin
      prod_q <= prod_d;
    end
  end

  assign done_o    = done_q;
  assign product_o = prod_q;

endmodule

### hw/rtl/spo2_sdiv.sv
// Restoring divider, one quotient bit per cycle.
module spo2_sdiv #(
  parameter int unsigned DVD_BITS = spo2_pkg::SUM_BITS,
  parameter int unsigned DVS_BITS = spo2_pkg::COUNT_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [DVD_BITS-1:0] dividend_i,
  input  logic [DVS_BITS-1:0] divisor_i,
  output logic                done_o,
  output logic [DVD_BITS-1:0] quotient_o,
  output logic [DVS_BITS-1:0] remainder_o
);

  localparam int unsigned CNT_BITS = $clog2(DVD_BITS + 1);

  logic [CNT_BITS-1:0] cnt_q;
  logic                done_q;
  logic [DVD_BITS-1:0] dvd_q, dvd_d;
  logic [DVS_BITS-1:0] dvs_q;
  logic [DVS_BITS-1:0] rem_q, rem_d;
  logic [DVS_BITS:0]   trial, diff;
  logic                ge;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    trial = {rem_q, dvd_q[DVD_BITS-1]};
    diff  = trial - {1'b0, dvs_q};
    ge    = (trial >= {1'b0, dvs_q});
    rem_d = ge ? diff[DVS_BITS-1:0] : trial[DVS_BITS-1:0];
    dvd_d = {dvd_q[DVD_BITS-2:0], ge};
  end

  // Step counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CNT_BITS'(DVD_BITS);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - CNT_BITS'(1);
      done_q <= (cnt_q == CNT_BITS'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  // Quotient shifts into the dividend register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = dvd_q;
  assign remainder_o = rem_q;

endmodule

### hw/rtl/spo2_ratio_estimator_unit.sv
// Channel   Signals                                            Direction
// input     in_valid_i / in_ready_o, ir_ac_i, red_ac_i,        in
//           beat_detected_i, restart_i
// output    out_valid_o / out_ready_i, spo2_percent_o,         out
//           new_value_o
// config    cfg_we_i, cfg_wdata_i (beats_per_calc)             in
//
// One item at a time. A plain sample takes accept, two serial squarings in the shared
// multiplier, accumulate and output load. A restart item takes accept and output load.
// An item that completes a beat window adds up to three serial divides, a normalize
// shift per leading zero for each logarithm, up to sixteen squarings for the two
// logarithms and a store step.
// Reset is asynchronous and clears sums, counts and the stored saturation.
// A stalled output holds in its register; the next item is taken meanwhile and
// waits before the output load until the register frees up.
module spo2_ratio_estimator_unit #(
  parameter int unsigned SAMPLE_BITS = spo2_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned COUNT_BITS  = spo2_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]       ir_ac_i,
  input  logic signed [SAMPLE_BITS-1:0]       red_ac_i,
  input  logic                                beat_detected_i,
  input  logic                                restart_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [spo2_pkg::PCT_BITS-1:0]       spo2_percent_o,
  output logic                                new_value_o,
  input  logic                                cfg_we_i,
  input  logic [spo2_pkg::BEAT_BITS-1:0]      cfg_wdata_i
);

  localparam int unsigned SUM_BITS  = spo2_pkg::SUM_BITS;
  localparam int unsigned MUL_BITS  = spo2_pkg::MUL_BITS;
  localparam int unsigned Y_BITS    = spo2_pkg::Y_BITS;
  localparam int unsigned EXP_BITS  = spo2_pkg::EXP_BITS;
  localparam int unsigned FRAC_BITS = spo2_pkg::FRAC_BITS;
  localparam int unsigned LOG_BITS  = spo2_pkg::LOG_BITS;
  localparam int unsigned NUM_BITS  = spo2_pkg::NUM_BITS;
  localparam int unsigned BEAT_BITS = spo2_pkg::BEAT_BITS;
  localparam int unsigned PCT_BITS  = spo2_pkg::PCT_BITS;
  localparam int unsigned IDX_BITS  = spo2_pkg::IDX_BITS;
  localparam int unsigned DVS_BITS  = (COUNT_BITS > LOG_BITS) ? COUNT_BITS : LOG_BITS;
  localparam int unsigned ITER_BITS = $clog2(FRAC_BITS);

  typedef enum logic [10:0] {
    ST_IDLE      = 11'b000_0000_0001,
    ST_SQ_IR     = 11'b000_0000_0010,
    ST_SQ_RED    = 11'b000_0000_0100,
    ST_ACC       = 11'b000_0000_1000,
    ST_DIV_IR    = 11'b000_0001_0000,
    ST_DIV_RED   = 11'b000_0010_0000,
    ST_NORM      = 11'b000_0100_0000,
    ST_LOG_MUL   = 11'b000_1000_0000,
    ST_DIV_RATIO = 11'b001_0000_0000,
    ST_STORE     = 11'b010_0000_0000,
    ST_FINISH    = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  // Architectural state
  logic [SUM_BITS-1:0]   ir_sum_q, ir_sum_d;
  logic [SUM_BITS-1:0]   red_sum_q, red_sum_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic [BEAT_BITS-1:0]  beat_cnt_q, beat_cnt_d;
  logic [PCT_BITS-1:0]   sat_q, sat_d;
  logic [BEAT_BITS-1:0]  bpc_q;
  logic                  fresh_q, fresh_d;

  // Working registers
  logic [SAMPLE_BITS-1:0] red_q, red_d;
  logic                   beat_q, beat_d;
  logic [SUM_BITS-1:0]    norm_q, norm_d;
  logic [EXP_BITS-1:0]    exp_q, exp_d;
  logic [FRAC_BITS-1:0]   frac_q, frac_d;
  logic [ITER_BITS-1:0]   iter_q, iter_d;
  logic                   red_phase_q, red_phase_d;
  logic [LOG_BITS-1:0]    li_q, li_d;
  logic [IDX_BITS-1:0]    idx_q, idx_d;

  // Output register
  logic                out_valid_q, out_valid_d;
  logic [PCT_BITS-1:0] spo2_q, spo2_d;
  logic                new_q, new_d;

  // Shared arithmetic units
  logic                  mul_start, mul_done;
  logic [MUL_BITS-1:0]   mul_a;
  logic [2*MUL_BITS-1:0] mul_prod;
  logic                  div_start, div_done;
  logic [SUM_BITS-1:0]   div_dvd, div_quo;
  logic [DVS_BITS-1:0]   div_dvs, div_rem;

  // Misc datapath
  logic [SAMPLE_BITS-1:0] ir_raw, ir_mag, red_mag;
  logic [Y_BITS:0]        log_t;
  logic [LOG_BITS-1:0]    log_val;
  logic [NUM_BITS-1:0]    ratio_num;
  logic [BEAT_BITS-1:0]   beat_next;
  logic                   above_hi, above_lo;
  logic [SUM_BITS-1:0]    diff_hi, diff_lo;
  logic [IDX_BITS-1:0]    ratio_idx;

  spo2_smul #(
    .OP_BITS (MUL_BITS)
  ) u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .a_i       (mul_a),
    .b_i       (mul_a),
    .done_o    (mul_done),
    .product_o (mul_prod)
  );

  spo2_sdiv #(
    .DVD_BITS (SUM_BITS),
    .DVS_BITS (DVS_BITS)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dvd),
    .divisor_i   (div_dvs),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // Sample magnitudes
  assign ir_raw  = ir_ac_i;
  assign ir_mag  = ir_raw[SAMPLE_BITS-1] ? (~ir_raw + SAMPLE_BITS'(1)) : ir_raw;
  assign red_mag = red_q[SAMPLE_BITS-1] ? (~red_q + SAMPLE_BITS'(1)) : red_q;

  // Log iteration: square >> 30, take a fraction bit, renormalize
  assign log_t     = mul_prod[2*Y_BITS-1:Y_BITS-1];
  assign log_val   = {exp_q, frac_q[FRAC_BITS-2:0], log_t[Y_BITS]};
  assign ratio_num = NUM_BITS'(log_val) * NUM_BITS'(spo2_pkg::RATIO_SCALE);
  assign beat_next = beat_cnt_q + BEAT_BITS'(1);

  // Ratio to table index
  always_comb begin
    above_hi = (div_quo > SUM_BITS'(spo2_pkg::RATIO_HI)) ||
               ((div_quo == SUM_BITS'(spo2_pkg::RATIO_HI)) && (div_rem != '0));
    above_lo = (div_quo > SUM_BITS'(spo2_pkg::RATIO_LO)) ||
               ((div_quo == SUM_BITS'(spo2_pkg::RATIO_LO)) && (div_rem != '0));
    diff_hi  = div_quo - SUM_BITS'(spo2_pkg::RATIO_HI);
    diff_lo  = div_quo - SUM_BITS'(spo2_pkg::RATIO_LO);
    if (above_hi) begin
      ratio_idx = (diff_hi > SUM_BITS'(spo2_pkg::IDX_MAX)) ?
                  IDX_BITS'(spo2_pkg::IDX_MAX) : diff_hi[IDX_BITS-1:0];
    end else if (above_lo) begin
      ratio_idx = diff_lo[IDX_BITS-1:0];
    end else begin
      ratio_idx = '0;
    end
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    ir_sum_d    = ir_sum_q;
    red_sum_d   = red_sum_q;
    count_d     = count_q;
    beat_cnt_d  = beat_cnt_q;
    sat_d       = sat_q;
    fresh_d     = fresh_q;
    red_d       = red_q;
    beat_d      = beat_q;
    norm_d      = norm_q;
    exp_d       = exp_q;
    frac_d      = frac_q;
    iter_d      = iter_q;
    red_phase_d = red_phase_q;
    li_d        = li_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    spo2_d      = spo2_q;
    new_d       = new_q;
    mul_start   = 1'b0;
    mul_a       = MUL_BITS'(ir_mag);
    div_start   = 1'b0;
    div_dvd     = ir_sum_q;
    div_dvs     = DVS_BITS'(count_q);

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          red_d  = red_ac_i;
          beat_d = beat_detected_i;
          if (restart_i) begin
            ir_sum_d   = '0;
            red_sum_d  = '0;
            count_d    = '0;
            beat_cnt_d = '0;
            sat_d      = '0;
            fresh_d    = 1'b0;
            state_d    = ST_FINISH;
          end else begin
            mul_start = 1'b1;
            state_d   = ST_SQ_IR;
          end
        end
      end
      ST_SQ_IR: begin
        mul_a = MUL_BITS'(red_mag);
        if (mul_done) begin
          ir_sum_d  = spo2_pkg::sat_add(ir_sum_q, mul_prod[SUM_BITS-1:0]);
          mul_start = 1'b1;
          state_d   = ST_SQ_RED;
        end
      end
      ST_SQ_RED: begin
        if (mul_done) begin
          red_sum_d = spo2_pkg::sat_add(red_sum_q, mul_prod[SUM_BITS-1:0]);
          state_d   = ST_ACC;
        end
      end
      ST_ACC: begin
        if (count_q != {COUNT_BITS{1'b1}}) begin
          count_d = count_q + COUNT_BITS'(1);
        end
        fresh_d = 1'b0;
        state_d = ST_FINISH;
        if (beat_q) begin
          beat_cnt_d = beat_next;
          if (beat_next == bpc_q) begin
            div_start = 1'b1;
            div_dvs   = DVS_BITS'(count_d);
            state_d   = ST_DIV_IR;
          end
        end
      end
      ST_DIV_IR: begin
        if (div_done) begin
          if (div_quo <= SUM_BITS'(1)) begin
            idx_d   = '0;
            state_d = ST_STORE;
          end else begin
            norm_d      = div_quo;
            exp_d       = EXP_BITS'(SUM_BITS - 1);
            red_phase_d = 1'b0;
            state_d     = ST_NORM;
          end
        end
      end
      ST_DIV_RED: begin
        if (div_done) begin
          if (div_quo == '0) begin
            idx_d   = '0;
            state_d = ST_STORE;
          end else begin
            norm_d      = div_quo;
            exp_d       = EXP_BITS'(SUM_BITS - 1);
            red_phase_d = 1'b1;
            state_d     = ST_NORM;
          end
        end
      end
      ST_NORM: begin
        // one shift per cycle until the leading one reaches the top
        mul_a = MUL_BITS'(norm_q[SUM_BITS-1 -: Y_BITS]);
        if (norm_q[SUM_BITS-1]) begin
          frac_d    = '0;
          iter_d    = '0;
          mul_start = 1'b1;
          state_d   = ST_LOG_MUL;
        end else begin
          norm_d = {norm_q[SUM_BITS-2:0], 1'b0};
          exp_d  = exp_q - EXP_BITS'(1);
        end
      end
      ST_LOG_MUL: begin
        mul_a = MUL_BITS'(log_t[Y_BITS] ? log_t[Y_BITS:1] : log_t[Y_BITS-1:0]);
        if (mul_done) begin
          frac_d = {frac_q[FRAC_BITS-2:0], log_t[Y_BITS]};
          if (iter_q == ITER_BITS'(FRAC_BITS - 1)) begin
            div_start = 1'b1;
            if (!red_phase_q) begin
              li_d    = log_val;
              div_dvd = red_sum_q;
              state_d = ST_DIV_RED;
            end else begin
              div_dvd = SUM_BITS'(ratio_num);
              div_dvs = DVS_BITS'(li_q);
              state_d = ST_DIV_RATIO;
            end
          end else begin
            iter_d    = iter_q + ITER_BITS'(1);
            mul_start = 1'b1;
          end
        end
      end
      ST_DIV_RATIO: begin
        if (div_done) begin
          idx_d   = ratio_idx;
          state_d = ST_STORE;
        end
      end
      ST_STORE: begin
        ir_sum_d   = '0;
        red_sum_d  = '0;
        count_d    = '0;
        beat_cnt_d = '0;
        sat_d      = spo2_pkg::SAT_TABLE[idx_q];
        fresh_d    = 1'b1;
        state_d    = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          spo2_d      = sat_q;
          new_d       = fresh_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ir_sum_q    <= '0;
      red_sum_q   <= '0;
      count_q     <= '0;
      beat_cnt_q  <= '0;
      sat_q       <= '0;
      fresh_q     <= 1'b0;
      iter_q      <= '0;
      red_phase_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ir_sum_q    <= ir_sum_d;
      red_sum_q   <= red_sum_d;
      count_q     <= count_d;
      beat_cnt_q  <= beat_cnt_d;
      sat_q       <= sat_d;
      fresh_q     <= fresh_d;
      iter_q      <= iter_d;
      red_phase_q <= red_phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpc_q <= spo2_pkg::BEATS_RESET;
    end else if (cfg_we_i) begin
      bpc_q <= cfg_wdata_i;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    red_q  <= red_d;
    beat_q <= beat_d;
    norm_q <= norm_d;
    exp_q  <= exp_d;
    frac_q <= frac_d;
    li_q   <= li_d;
    idx_q  <= idx_d;
    spo2_q <= spo2_d;
    new_q  <= new_d;
  end

  assign in_ready_o     = (state_q == ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign spo2_percent_o = spo2_q;
  assign new_value_o    = new_q;

endmodule

### hw/rtl/spo2_checker.sv
// Port-level checks for the saturation estimator.
module spo2_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [spo2_pkg::PCT_BITS-1:0] spo2_percent_o,
  input logic                          new_value_o
);

  // Stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // Stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(spo2_percent_o) && $stable(new_value_o))
    else $error("result payload changed while stalled");

  // Saturation is either none yet or a table value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (spo2_percent_o == '0) ||
                    ((spo2_percent_o >= spo2_pkg::PCT_BITS'(spo2_pkg::SAT_FLOOR)) &&
                     (spo2_percent_o <= spo2_pkg::PCT_BITS'(spo2_pkg::SAT_CEIL))))
    else $error("saturation outside table range");

  // A fresh computation always carries a table value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && new_value_o |-> spo2_percent_o != '0)
    else $error("new value flagged with empty saturation");

  // One item in flight: no transfer right after a transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken on back-to-back cycles");

endmodule

bind spo2_ratio_estimator_unit spo2_checker u_spo2_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .spo2_percent_o (spo2_percent_o),
  .new_value_o    (new_value_o)
);
